### hdl/seeded_block_byte_cipher_assert.svh
// Assertion macros used by the checker file of the seeded byte cipher.
`ifndef SEEDED_BLOCK_BYTE_CIPHER_ASSERT_SVH
`define SEEDED_BLOCK_BYTE_CIPHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SBBC_ASSERT_NOW(lbl, clk, rst_n, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SBBC_ASSERT_NEXT(lbl, clk, rst_n, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);

`endif

### hdl/sbbc_pkg.sv
// Package with types, codes and block transforms of the seeded byte cipher.
`default_nettype none

package sbbc_pkg;

  // Bytes in one cipher block and most result bytes one input can cause.
  localparam int unsigned BLK_BYTES = 4;
  localparam int unsigned MAX_RES   = 5;
  localparam int unsigned CNT_W     = $clog2(MAX_RES + 1);

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED = 1'b1;

  // Mode codes.
  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  typedef logic [7:0] byte_t;
  typedef logic [BLK_BYTES-1:0][7:0] block_t;

  // A group of result bytes handed from the transform to the output stage.
  // Byte 0 leaves first; last marks the group's final byte as the end of the message.
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    logic [CNT_W-1:0]        cnt;
    logic                    last;
  } group_t;

  // Forward transform of one block.
  function automatic block_t enc_block(block_t b, byte_t s);
    block_t a;
    block_t c;
    byte_t  k;
    for (int i = 0; i < BLK_BYTES; i++) begin
      k    = s + 8'(i);
      a[i] = b[i] + k;
    end
    for (int i = 0; i < BLK_BYTES; i++) begin
      k    = s + 8'(i);
      c[i] = a[BLK_BYTES-1-i] ^ k;
    end
    c[0] = c[0] ^ c[2];
    c[1] = c[1] ^ c[3];
    return c;
  endfunction

  // Inverse transform of one block.
  function automatic block_t dec_block(block_t b, byte_t s);
    block_t a;
    block_t c;
    byte_t  k;
    a    = b;
    a[0] = b[0] ^ b[2];
    a[1] = b[1] ^ b[3];
    // The key byte belongs to the position before the swap.
    for (int i = 0; i < BLK_BYTES; i++) begin
      k    = s + 8'(BLK_BYTES-1-i);
      c[i] = a[BLK_BYTES-1-i] ^ k;
    end
    for (int i = 0; i < BLK_BYTES; i++) begin
      k    = s + 8'(i);
      a[i] = c[i] - k;
    end
    return a;
  endfunction

endpackage

`default_nettype wire

### hdl/sbbc_stream_if.sv
// Stream interfaces for the input bytes and the result bytes of the cipher.
`default_nettype none

interface sbbc_in_if;
  logic valid;
  logic ready;
  logic [7:0] data_byte;
  logic last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface sbbc_out_if;
  logic valid;
  logic ready;
  logic [7:0] out_byte;
  logic out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

### hdl/seeded_block_byte_cipher.sv
// When the output is idle, the first result byte of an input transfer is offered in the next cycle.
// A block leaves as 4 bytes (5 with the encrypt header), one per cycle while the output is ready.
// A parking register behind the output shift register lets input take one byte per cycle
// while a block drains; input stalls only while a group waits in that register.
// Reset (synchronous, active low): mode encrypt, seed zero, next byte starts a message.
`default_nettype none

module seeded_block_byte_cipher (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [sbbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [7:0]                      cfg_data,
  sbbc_in_if.sink                              in_ch,
  sbbc_out_if.source                           out_ch
);

  sbbc_pkg::group_t grp;
  logic             grp_load;
  logic             slot_free;
  logic             in_fire;

  // Input transfers wait only while a result group is parked behind the output register.
  assign in_ch.ready = slot_free;
  assign in_fire     = in_ch.valid && slot_free;

  // Transform and message state.
  sbbc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_fire   (in_fire),
    .in_data   (in_ch.data_byte),
    .in_last   (in_ch.last_byte),
    .grp       (grp),
    .grp_load  (grp_load)
  );

  // Result byte output.
  sbbc_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp       (grp),
    .grp_load  (grp_load),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.out_last),
    .slot_free (slot_free)
  );

endmodule

`default_nettype wire

### hdl/sbbc_core.sv
// Message state, configuration registers and the block transform of the cipher.
`default_nettype none

module sbbc_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [sbbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [7:0]                      cfg_data,
  input  wire logic                            in_fire,
  input  wire logic [7:0]                      in_data,
  input  wire logic                            in_last,
  output sbbc_pkg::group_t                     grp,
  output logic                                 grp_load
);

  logic             mode_r;
  logic [7:0]       seed_r;
  logic             hdr_pend_r;
  logic             hdr_pend_nxt;
  logic [1:0]       cnt_r;
  logic [1:0]       cnt_nxt;
  logic [7:0]       mseed_r;
  logic [7:0]       mseed_nxt;
  logic [7:0]       buf_r [0:2];
  logic             buf_we;
  logic [1:0]       eff_cnt;
  logic [7:0]       blk_seed;
  sbbc_pkg::block_t blk_in;
  sbbc_pkg::block_t blk_out;
  sbbc_pkg::group_t grp_nxt;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sbbc_pkg::MODE_ENC;
      seed_r <= 8'h00;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sbbc_pkg::CFG_MODE: mode_r <= cfg_data[0];
        sbbc_pkg::CFG_SEED: seed_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Assemble the block: held bytes, then the new byte, then zero padding.
  always_comb begin
    eff_cnt = hdr_pend_r ? 2'd0 : cnt_r;
    for (int i = 0; i < 3; i++) begin
      blk_in[i] = (2'(i) < eff_cnt) ? buf_r[i] : 8'h00;
    end
    blk_in[3] = 8'h00;
    blk_in[eff_cnt] = in_data;
    // A decrypt header that is also the last byte decrypts a block of zeros.
    if (hdr_pend_r && (mode_r == sbbc_pkg::MODE_DEC)) begin
      blk_in   = '0;
      blk_seed = in_data;
    end else begin
      blk_seed = hdr_pend_r ? seed_r : mseed_r;
    end
    blk_out = (mode_r == sbbc_pkg::MODE_DEC) ? sbbc_pkg::dec_block(blk_in, blk_seed)
                                             : sbbc_pkg::enc_block(blk_in, blk_seed);
  end

  // Next state and the result group of the accepted byte.
  always_comb begin
    hdr_pend_nxt  = hdr_pend_r;
    cnt_nxt       = cnt_r;
    mseed_nxt     = mseed_r;
    buf_we        = 1'b0;
    grp_nxt.bytes = {8'h00, blk_out};
    grp_nxt.cnt   = sbbc_pkg::CNT_W'(0);
    grp_nxt.last  = in_last;
    if (hdr_pend_r && (mode_r == sbbc_pkg::MODE_DEC)) begin
      // Decrypt header: take the seed, emit only if the message ends here.
      mseed_nxt    = in_data;
      cnt_nxt      = 2'd0;
      hdr_pend_nxt = in_last;
      if (in_last) begin
        grp_nxt.cnt = sbbc_pkg::CNT_W'(sbbc_pkg::BLK_BYTES);
      end
    end else begin
      if (hdr_pend_r) begin
        mseed_nxt     = seed_r;
        grp_nxt.bytes = {blk_out, seed_r};
        grp_nxt.cnt   = sbbc_pkg::CNT_W'(1);
      end
      if ((eff_cnt == 2'd3) || in_last) begin
        grp_nxt.cnt = grp_nxt.cnt + sbbc_pkg::CNT_W'(sbbc_pkg::BLK_BYTES);
        cnt_nxt     = 2'd0;
      end else begin
        buf_we  = 1'b1;
        cnt_nxt = eff_cnt + 2'd1;
      end
      hdr_pend_nxt = in_last;
    end
  end

  // Message state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pend_r <= 1'b1;
      cnt_r      <= 2'd0;
      mseed_r    <= 8'h00;
    end else if (in_fire) begin
      hdr_pend_r <= hdr_pend_nxt;
      cnt_r      <= cnt_nxt;
      mseed_r    <= mseed_nxt;
    end
  end

  // Bytes of the block being collected; only entries below the count are read.
  always_ff @(posedge clk) begin
    if (in_fire && buf_we) begin
      buf_r[eff_cnt] <= in_data;
    end
  end

  assign grp      = grp_nxt;
  assign grp_load = in_fire && (grp_nxt.cnt != sbbc_pkg::CNT_W'(0));

endmodule

`default_nettype wire

### hdl/sbbc_serializer.sv
// Output register that sends a group of result bytes one per transfer.
`default_nettype none

module sbbc_serializer (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sbbc_pkg::group_t  grp,
  input  wire logic              grp_load,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [7:0]             out_byte,
  output logic                   out_last,
  output logic                   slot_free
);

  logic [sbbc_pkg::MAX_RES-1:0][7:0] bytes_r;
  logic [sbbc_pkg::CNT_W-1:0]        rem_r;
  logic                              last_r;
  sbbc_pkg::group_t                  pend_r;
  logic                              pend_vld_r;
  logic                              out_fire;
  logic                              load_ok;

  assign out_valid = (rem_r != sbbc_pkg::CNT_W'(0));
  assign out_fire  = out_valid && out_ready;
  assign out_byte  = bytes_r[0];
  assign out_last  = last_r && (rem_r == sbbc_pkg::CNT_W'(1));

  // The shift register takes a new group once the current one is gone or leaves this cycle.
  assign load_ok = !out_valid || ((rem_r == sbbc_pkg::CNT_W'(1)) && out_ready);

  // A new group is accepted while the parking register is empty.
  assign slot_free = !pend_vld_r;

  // Remaining byte count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= sbbc_pkg::CNT_W'(0);
    end else if (load_ok && pend_vld_r) begin
      rem_r <= pend_r.cnt;
    end else if (load_ok && grp_load) begin
      rem_r <= grp.cnt;
    end else if (out_fire) begin
      rem_r <= rem_r - sbbc_pkg::CNT_W'(1);
    end
  end

  // Byte shift register and last flag.
  always_ff @(posedge clk) begin
    if (load_ok && pend_vld_r) begin
      bytes_r <= pend_r.bytes;
      last_r  <= pend_r.last;
    end else if (load_ok && grp_load) begin
      bytes_r <= grp.bytes;
      last_r  <= grp.last;
    end else if (out_fire) begin
      bytes_r <= {8'h00, bytes_r[sbbc_pkg::MAX_RES-1:1]};
    end
  end

  // Parking register for a group that arrives while the shift register is busy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
    end else if (load_ok) begin
      pend_vld_r <= 1'b0;
    end else if (grp_load) begin
      pend_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_load && !load_ok) begin
      pend_r <= grp;
    end
  end

endmodule

`default_nettype wire

### hdl/sbbc_checker.sv
// Port checker for the seeded byte cipher and its bind to the top level.
`default_nettype none
`include "seeded_block_byte_cipher_assert.svh"

module sbbc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_last,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_last
);

  // A stalled result byte holds its value.
  `SBBC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last), "result byte changed while stalled")

  // After the last byte of a message is taken, a result byte is always offered in the next cycle.
  `SBBC_ASSERT_NEXT(a_last_emits, clk, rst_n, in_valid && in_ready && in_last, out_valid, "no result after last input byte")

  // Input is held back only by pending result bytes.
  `SBBC_ASSERT_NOW(a_ready_cause, clk, rst_n, !in_ready, out_valid, "input stalled with empty output")

endmodule

bind seeded_block_byte_cipher sbbc_checker u_sbbc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last_byte),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_last  (out_ch.out_last)
);

`default_nettype wire

### tb/sv/seeded_block_byte_cipher_tb.sv
// Self-checking testbench for the seeded block byte cipher: directed table, then random traffic.
`timescale 1ns / 100ps

module seeded_block_byte_cipher_tb;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned PHASE_BYTES   = 42;
  localparam int          NO_CHECK      = -1;

  typedef logic [sbbc_pkg::BLK_BYTES-1:0][7:0] quad_t;

  typedef struct packed {
    sbbc_pkg::byte_t data;
    logic            last;
  } cipher_out_t;

  typedef enum logic [1:0] {ROW_BYTE, ROW_MODE, ROW_SEED} row_kind_t;

  // One row of the directed table: a byte transfer or a register write.
  typedef struct {
    row_kind_t       kind;
    sbbc_pkg::byte_t value;
    logic            last;
    int              n_want;
    int              first_want;
  } row_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [sbbc_pkg::CFG_IDX_W-1:0] cfg_index;
  sbbc_pkg::byte_t                cfg_data;

  sbbc_in_if  in_if ();
  sbbc_out_if out_if ();

  seeded_block_byte_cipher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  // Predictor state: register copies and the running message.
  logic            cur_mode  = sbbc_pkg::MODE_ENC;
  sbbc_pkg::byte_t cur_seed  = '0;
  sbbc_pkg::byte_t held [3]  = '{default: '0};
  logic [1:0]      held_cnt  = '0;
  logic            msg_start = 1'b1;
  sbbc_pkg::byte_t msg_key   = '0;

  cipher_out_t expected_q [$];

  int cycle_count     = 0;
  int bytes_sent      = 0;
  int messages_sent   = 0;
  int results_checked = 0;
  int mismatches      = 0;
  int tx_idle_pct     = 0;
  int rx_stall_pct    = 0;
  int hold_requests   = 0;

  // Directed cases. Counts are typed in everywhere; the first byte only where it is the header.
  row_t directed_rows [30] = '{
    '{ROW_BYTE, 8'h00, 1'b0, 1, 8'h00},          // header after reset carries seed zero
    '{ROW_BYTE, 8'hFF, 1'b0, 0, NO_CHECK},
    '{ROW_BYTE, 8'h80, 1'b0, 0, NO_CHECK},
    '{ROW_BYTE, 8'h01, 1'b0, 4, NO_CHECK},
    '{ROW_BYTE, 8'hFF, 1'b1, 4, NO_CHECK},       // short final block, zero padded
    '{ROW_SEED, 8'hFF, 1'b0, 0, NO_CHECK},
    '{ROW_BYTE, 8'hA5, 1'b1, 5, 8'hFF},          // one-byte message: header plus block
    '{ROW_SEED, 8'h3C, 1'b0, 0, NO_CHECK},
    '{ROW_BYTE, 8'h11, 1'b0, 1, 8'h3C},
    '{ROW_BYTE, 8'h22, 1'b0, 0, NO_CHECK},
    '{ROW_SEED, 8'h00, 1'b0, 0, NO_CHECK},       // new seed must wait for the next message
    '{ROW_BYTE, 8'h33, 1'b0, 0, NO_CHECK},
    '{ROW_BYTE, 8'h44, 1'b1, 4, NO_CHECK},       // exact multiple of four, no extra block
    '{ROW_MODE, sbbc_pkg::byte_t'(sbbc_pkg::MODE_DEC), 1'b0, 0, NO_CHECK},
    '{ROW_BYTE, 8'h7E, 1'b1, 4, NO_CHECK},       // header-only decrypt message
    '{ROW_BYTE, 8'hFF, 1'b0, 0, NO_CHECK},
    '{ROW_BYTE, 8'h00, 1'b0, 0, NO_CHECK},
    '{ROW_BYTE, 8'hFF, 1'b0, 0, NO_CHECK},
    '{ROW_BYTE, 8'h5A, 1'b0, 0, NO_CHECK},
    '{ROW_BYTE, 8'hC3, 1'b1, 4, NO_CHECK},
    '{ROW_BYTE, 8'h00, 1'b0, 0, NO_CHECK},
    '{ROW_BYTE, 8'h12, 1'b0, 0, NO_CHECK},
    '{ROW_MODE, sbbc_pkg::byte_t'(sbbc_pkg::MODE_ENC), 1'b0, 0, NO_CHECK},
    '{ROW_BYTE, 8'h34, 1'b1, 4, NO_CHECK},       // mode flipped mid-message, no header
    '{ROW_BYTE, 8'h56, 1'b0, 1, 8'h00},
    '{ROW_MODE, sbbc_pkg::byte_t'(sbbc_pkg::MODE_DEC), 1'b0, 0, NO_CHECK},
    '{ROW_BYTE, 8'h78, 1'b0, 0, NO_CHECK},
    '{ROW_BYTE, 8'h9A, 1'b0, 0, NO_CHECK},
    '{ROW_BYTE, 8'hBC, 1'b0, 4, NO_CHECK},
    '{ROW_BYTE, 8'hDE, 1'b1, 4, NO_CHECK}
  };

  // Forward block transform with key byte k.
  function automatic quad_t scramble(quad_t p, sbbc_pkg::byte_t k);
    quad_t           a;
    sbbc_pkg::byte_t t;
    for (int i = 0; i < sbbc_pkg::BLK_BYTES; i++) a[i] = p[i] + k + 8'(i);
    t = a[0]; a[0] = a[3]; a[3] = t;
    t = a[1]; a[1] = a[2]; a[2] = t;
    for (int i = 0; i < sbbc_pkg::BLK_BYTES; i++) a[i] = a[i] ^ (k + 8'(i));
    a[0] ^= a[2];
    a[1] ^= a[3];
    return a;
  endfunction

  // Inverse block transform with key byte k.
  function automatic quad_t unscramble(quad_t c, sbbc_pkg::byte_t k);
    quad_t           a;
    sbbc_pkg::byte_t t;
    a = c;
    a[0] ^= a[2];
    a[1] ^= a[3];
    for (int i = 0; i < sbbc_pkg::BLK_BYTES; i++) a[i] = a[i] ^ (k + 8'(i));
    t = a[0]; a[0] = a[3]; a[3] = t;
    t = a[1]; a[1] = a[2]; a[2] = t;
    for (int i = 0; i < sbbc_pkg::BLK_BYTES; i++) a[i] = a[i] - k - 8'(i);
    return a;
  endfunction

  // Transforms a block in the current mode and queues its four bytes; returns the first.
  function automatic sbbc_pkg::byte_t queue_block(quad_t p, logic msg_end);
    quad_t       c;
    cipher_out_t e;
    c = (cur_mode == sbbc_pkg::MODE_DEC) ? unscramble(p, msg_key) : scramble(p, msg_key);
    for (int i = 0; i < sbbc_pkg::BLK_BYTES; i++) begin
      e.data = c[i];
      e.last = msg_end && (i == sbbc_pkg::BLK_BYTES - 1);
      expected_q.push_back(e);
    end
    return c[0];
  endfunction

  // Works out the output bytes of one input transfer; returns their count.
  function automatic int predict_byte(sbbc_pkg::byte_t d, logic msg_end,
                                      output sbbc_pkg::byte_t first);
    quad_t           p;
    cipher_out_t     e;
    sbbc_pkg::byte_t b0;
    int              n;
    n     = 0;
    first = '0;
    if (msg_start) begin
      msg_start = 1'b0;
      held_cnt  = '0;
      if (cur_mode == sbbc_pkg::MODE_DEC) begin
        // The first byte is the key; alone it still yields the decrypt of a block of zeros.
        msg_key = d;
        if (msg_end) begin
          first     = queue_block('0, 1'b1);
          msg_start = 1'b1;
          n         = sbbc_pkg::BLK_BYTES;
        end
        return n;
      end
      msg_key = cur_seed;
      e.data  = msg_key;
      e.last  = 1'b0;
      expected_q.push_back(e);
      first = msg_key;
      n     = 1;
    end
    if (held_cnt == 2'd3 || msg_end) begin
      p = '0;
      for (int i = 0; i < held_cnt; i++) p[i] = held[i];
      p[held_cnt] = d;
      b0 = queue_block(p, msg_end);
      if (n == 0) first = b0;
      n        = n + sbbc_pkg::BLK_BYTES;
      held_cnt = '0;
      held     = '{default: '0};
    end else begin
      held[held_cnt] = d;
      held_cnt       = held_cnt + 2'd1;
    end
    if (msg_end) msg_start = 1'b1;
    return n;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("Mismatch at cycle %0d: %s is %0h, expected %0h", cycle_count, what, got, want);
    mismatches++;
  endtask

  // Offers one byte until the transfer happens, then may leave a random gap.
  task automatic send_byte(sbbc_pkg::byte_t d, logic msg_end, output int n,
                           output sbbc_pkg::byte_t first);
    in_if.valid     <= 1'b1;
    in_if.data_byte <= d;
    in_if.last_byte <= msg_end;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    n = predict_byte(d, msg_end, first);
    bytes_sent++;
    if (msg_end) messages_sent++;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  // Stops offering input and waits for every expected byte plus a few settling cycles.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Single-cycle register write, then cfg_we drops; the predictor takes it at the write edge.
  task automatic write_cfg(logic [sbbc_pkg::CFG_IDX_W-1:0] idx, sbbc_pkg::byte_t v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    if (idx == sbbc_pkg::CFG_MODE) cur_mode = v[0];
    else if (idx == sbbc_pkg::CFG_SEED) cur_seed = v;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Sends a random message, with an occasional register write between its bytes.
  task automatic send_message(int len);
    sbbc_pkg::byte_t d;
    sbbc_pkg::byte_t first;
    int              n;
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(99) < 4) begin
        wait_idle();
        if ($urandom_range(1) == 1) write_cfg(sbbc_pkg::CFG_MODE, 8'($urandom_range(255)));
        else write_cfg(sbbc_pkg::CFG_SEED, 8'($urandom_range(255)));
      end
      d = 8'($urandom_range(255));
      if ($urandom_range(7) == 0) d = ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
      send_byte(d, i == len - 1, n, first);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Cycle count and run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run limit reached with %0d output bytes still expected.", expected_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold counted here whenever one is requested.
  initial begin
    int hold_served;
    int hold_left;
    hold_served = 0;
    hold_left   = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Output checker: each transfer against the oldest expected byte.
  always @(posedge clk) begin
    cipher_out_t want;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected output byte", int'(out_if.out_byte), 0);
      end else begin
        want = expected_q.pop_front();
        results_checked++;
        if (out_if.out_byte !== want.data)
          report_mismatch("out_byte", int'(out_if.out_byte), int'(want.data));
        if (out_if.out_last !== want.last)
          report_mismatch("out_last", int'(out_if.out_last), int'(want.last));
      end
    end
  end

  // Stimulus: reset, directed table, then five traffic phases.
  initial begin
    int              n;
    sbbc_pkg::byte_t first;
    int              len;
    int              phase_start;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= sbbc_pkg::CFG_MODE;
    cfg_data        <= '0;
    in_if.valid     <= 1'b0;
    in_if.data_byte <= '0;
    in_if.last_byte <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, with no idling on either side.
    for (int r = 0; r < $size(directed_rows); r++) begin
      case (directed_rows[r].kind)
        ROW_BYTE: begin
          send_byte(directed_rows[r].value, directed_rows[r].last, n, first);
          if (n != directed_rows[r].n_want)
            report_mismatch("output count of a directed byte", n, directed_rows[r].n_want);
          if (directed_rows[r].first_want != NO_CHECK && int'(first) != directed_rows[r].first_want)
            report_mismatch("header byte", int'(first), directed_rows[r].first_want);
        end
        ROW_MODE: begin
          wait_idle();
          write_cfg(sbbc_pkg::CFG_MODE, directed_rows[r].value);
        end
        default: begin
          wait_idle();
          write_cfg(sbbc_pkg::CFG_SEED, directed_rows[r].value);
        end
      endcase
    end
    wait_idle();

    // Random messages: free flow, sender gaps, receiver stalls, both, then a long output hold.
    for (int p = 0; p < 5; p++) begin
      case (p)
        1:       begin tx_idle_pct = 68; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 68; end
        3:       begin tx_idle_pct = 28; rx_stall_pct = 28; end
        default: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      endcase
      if (p == 4) hold_requests++;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        if ($urandom_range(9) < 3) begin
          wait_idle();
          write_cfg(sbbc_pkg::CFG_MODE, 8'($urandom_range(255)));
          if ($urandom_range(1) == 1) begin
            first = 8'($urandom_range(255));
            if ($urandom_range(3) == 0) first = ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
            write_cfg(sbbc_pkg::CFG_SEED, first);
          end
        end
        len = ($urandom_range(7) == 0) ? $urandom_range(20, 10) : $urandom_range(9, 1);
        send_message(len);
      end
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d bytes in %0d messages: directed cases, then free flow, gaps, stalls",
             bytes_sent, messages_sent);
    $display("and a long output hold; %0d output bytes checked, %0d mismatches.",
             results_checked, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
